FILE: sv/nco_tw_pkg.sv
// ----------------------------------------------------------------------------
// NCO tuning word package
// Shared constants and types for the DDS tuning word calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package nco_tw_pkg;

  localparam int WORD_W        = 32;
  localparam int CLK_W         = 27;
  localparam int CORR_W        = 21;
  localparam int FREQ_BITS_DEF = 32;
  localparam int STEPS_PER_STG = 4;

  localparam logic [CLK_W-1:0] NOMINAL_FULL = 27'd122880000;
  localparam logic [CLK_W-1:0] NOMINAL_HALF = 27'd61440000;

  localparam logic [7:0]  REQ_SINGLE = 8'hF2;
  localparam logic [7:0]  REQ_DUAL   = 8'hE1;
  localparam logic [7:0]  DUAL_TAG   = 8'hF2;

  typedef enum logic [1:0] {
    MODEL_FULL = 2'd0,
    MODEL_HALF = 2'd1,
    MODEL_DUAL = 2'd2
  } device_model_e;

  typedef enum logic [0:0] {
    REG_MODEL = 1'b0,
    REG_CORR  = 1'b1
  } reg_idx_e;

  function automatic int unsigned pipe_stages(input int unsigned freq_bits);
    int unsigned fb;
    fb = (freq_bits > WORD_W) ? WORD_W : freq_bits;
    return (fb + WORD_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  endfunction

endpackage

`default_nettype wire

FILE: sv/nco_tuning_word_calc.sv
// ----------------------------------------------------------------------------
// NCO tuning word calculator
// Turns an LO frequency in Hz into a 32-bit DDS tuning word plus the fields
// of the device frequency command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive lo_frequency_i and pulse start; the item is taken
//   on any edge with start high and busy low. busy is always low, so a new
//   item may enter every cycle.
//   Output channel: done_o is high for one cycle with the result fields.
//   The receiver cannot stall; results are not held.
//   Throughput: one item per cycle.
//   The divider is a restoring long division of f * 2^32 by the effective
//   clock, one quotient bit per step, four steps per pipeline stage,
//   min(FREQ_BITS, 32) + 32 steps in all; the stage count sets the latency.
//   Config: APB port, device_model at 0x0, rate_correction at 0x4. Write
//   only while the pipe is empty. The effective clock register takes up a
//   write in the following cycle.
//   Reset clears both registers and drops all items in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module nco_tuning_word_calc
  import nco_tw_pkg::*;
#(
  parameter int unsigned FREQ_BITS = FREQ_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [WORD_W-1:0]  lo_frequency_i,
  output      logic               done_o,
  output      logic [WORD_W-1:0]  tuning_word_o,
  output      logic [15:0]        value_half_o,
  output      logic [15:0]        index_half_o,
  output      logic [7:0]         data_byte_o,
  output      logic [7:0]         request_code_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  localparam int unsigned FB      = (FREQ_BITS > WORD_W) ? WORD_W : FREQ_BITS;
  localparam int unsigned STEPS   = FB + WORD_W;
  localparam int unsigned NSTAGES = pipe_stages(FREQ_BITS);

  typedef struct packed {
    logic [CLK_W-1:0]  rem;
    logic [FB-1:0]     dvd;
    logic [WORD_W-1:0] quo;
  } stage_t;

  // config
  logic [1:0]        model_q;
  logic [CORR_W-1:0] corr_q;
  logic [CLK_W-1:0]  eff_clk_q, eff_clk_d;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_FULL;
      corr_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_MODEL: model_q <= pwdata[1:0];
        REG_CORR:  corr_q  <= pwdata[CORR_W-1:0];
        default:   model_q <= model_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[2]))
      REG_MODEL: prdata = {30'd0, model_q};
      REG_CORR:  prdata = {{(32-CORR_W){1'b0}}, corr_q};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    eff_clk_d = ((model_q == MODEL_HALF) ? NOMINAL_HALF : NOMINAL_FULL)
              + {{(CLK_W-CORR_W){corr_q[CORR_W-1]}}, corr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_clk_q <= NOMINAL_FULL;
    end else begin
      eff_clk_q <= eff_clk_d;
    end
  end

  // divider pipeline
  logic   [NSTAGES:0] vld_q;
  stage_t             st_q [NSTAGES+1];
  stage_t             st_d [NSTAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTAGES-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0].rem <= '0;
    st_q[0].dvd <= lo_frequency_i[FB-1:0];
    st_q[0].quo <= '0;
  end

  for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
    logic [CLK_W:0] trial;
    logic           qbit;

    always_comb begin
      st_d[g] = st_q[g];
      trial   = '0;
      qbit    = 1'b0;
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        if (g * STEPS_PER_STG + j < STEPS) begin
          trial = {st_d[g].rem, st_d[g].dvd[FB-1]};
          st_d[g].dvd = {st_d[g].dvd[FB-2:0], 1'b0};
          if (trial >= {1'b0, eff_clk_q}) begin
            trial = trial - {1'b0, eff_clk_q};
            qbit  = 1'b1;
          end else begin
            qbit  = 1'b0;
          end
          st_d[g].rem = trial[CLK_W-1:0];
          st_d[g].quo = {st_d[g].quo[WORD_W-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[g+1] <= st_d[g];
    end
  end

  // output register
  logic              done_q;
  logic [WORD_W-1:0] word_q;
  logic              dual;

  assign dual = (model_q == MODEL_DUAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NSTAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= st_q[NSTAGES].quo;
  end

  assign done_o         = done_q;
  assign tuning_word_o  = word_q;
  assign value_half_o   = word_q[15:0];
  assign index_half_o   = dual ? {DUAL_TAG, word_q[23:16]} : word_q[31:16];
  assign data_byte_o    = dual ? word_q[31:24] : word_q[23:16];
  assign request_code_o = dual ? REQ_DUAL : REQ_SINGLE;

endmodule

`default_nettype wire

FILE: sv/nco_tw_chk.sv
// ----------------------------------------------------------------------------
// NCO tuning word checker
// Port-level checks on result latency and command field packing.
// ----------------------------------------------------------------------------
`default_nettype none

module nco_tw_chk
  import nco_tw_pkg::*;
#(
  parameter int unsigned FREQ_BITS = FREQ_BITS_DEF
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic [WORD_W-1:0]  tuning_word_o,
  input wire logic [15:0]        value_half_o,
  input wire logic [15:0]        index_half_o,
  input wire logic [7:0]         data_byte_o,
  input wire logic [7:0]         request_code_o
);

  localparam int unsigned LAT = pipe_stages(FREQ_BITS) + 2;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("item not delivered after fixed latency");

  a_req_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (request_code_o == REQ_SINGLE || request_code_o == REQ_DUAL))
    else $error("bad request code");

  a_dual_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && request_code_o == REQ_DUAL) |->
      (index_half_o == {DUAL_TAG, tuning_word_o[23:16]} &&
       data_byte_o == tuning_word_o[31:24] &&
       value_half_o == tuning_word_o[15:0]))
    else $error("dual command fields mismatch");

  a_single_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && request_code_o == REQ_SINGLE) |->
      (index_half_o == tuning_word_o[31:16] &&
       data_byte_o == tuning_word_o[23:16] &&
       value_half_o == tuning_word_o[15:0]))
    else $error("single command fields mismatch");

endmodule

bind nco_tuning_word_calc nco_tw_chk #(.FREQ_BITS(FREQ_BITS)) u_nco_tw_chk (.*);

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// NCO tuning word calculator testbench
// Drives LO frequencies through the pipelined tuning word calculator under a
// series of device model and sample-rate correction settings, predicts every
// command field in exact integer arithmetic and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import nco_tw_pkg::*;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic [31:0] word;
    logic [15:0] value;
    logic [15:0] index;
    logic [7:0]  data;
    logic [7:0]  req;
  } tune_cmd_t;

  localparam int unsigned FREQ_BITS   = FREQ_BITS_DEF;
  localparam int unsigned LATENCY     = pipe_stages(FREQ_BITS) + 2;
  localparam logic [1:0]  MODEL_SPARE = 2'd3;
  localparam u64_t        FREQ_MASK   = (FREQ_BITS >= 32) ? 64'hFFFF_FFFF :
                                        ((64'd1 << FREQ_BITS) - 64'd1);
  localparam int unsigned PHASE_ITEMS = 150;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [31:0] lo_frequency_i = '0;
  logic        done_o;
  logic [31:0] tuning_word_o;
  logic [15:0] value_half_o;
  logic [15:0] index_half_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  request_code_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [1:0]  cur_model = MODEL_FULL;
  logic [20:0] cur_corr  = '0;

  logic [31:0] freq_q[$];
  tune_cmd_t   cmd_q[$];
  int          errors  = 0;
  int          gap_left = 0;
  bit          gaps_on = 1'b0;

  nco_tuning_word_calc #(.FREQ_BITS(FREQ_BITS)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .lo_frequency_i (lo_frequency_i),
    .done_o         (done_o),
    .tuning_word_o  (tuning_word_o),
    .value_half_o   (value_half_o),
    .index_half_o   (index_half_o),
    .data_byte_o    (data_byte_o),
    .request_code_o (request_code_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic u64_t sample_clock(input logic [1:0] model, input logic [20:0] corr);
    u64_t base;
    base = (model == MODEL_HALF) ? u64_t'(NOMINAL_HALF) : u64_t'(NOMINAL_FULL);
    return base + {{43{corr[20]}}, corr};
  endfunction

  function automatic tune_cmd_t calc_tune_cmd(input logic [31:0] freq);
    u64_t      f;
    u64_t      clk;
    u64_t      rem;
    u64_t      quo;
    tune_cmd_t c;
    f   = u64_t'(freq) & FREQ_MASK;
    clk = sample_clock(cur_model, cur_corr);
    rem = f % clk;
    quo = {rem[31:0], 32'd0} / clk;
    c.word  = quo[31:0];
    c.value = quo[15:0];
    if (cur_model == MODEL_DUAL) begin
      c.index = {DUAL_TAG, quo[23:16]};
      c.data  = quo[31:24];
      c.req   = REQ_DUAL;
    end else begin
      c.index = quo[31:16];
      c.data  = quo[23:16];
      c.req   = REQ_SINGLE;
    end
    return c;
  endfunction

  // mix of uniform values, points around multiples of the clock, values below the clock, small values and bit patterns
  function automatic logic [31:0] pick_freq();
    u64_t clk;
    u64_t f;
    int   k;
    clk = sample_clock(cur_model, cur_corr);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: f = u64_t'($urandom);
      4, 5: begin
        k = $urandom_range(0, 32'(64'hFFFF_FFFF / clk));
        f = u64_t'(k) * clk + u64_t'($urandom_range(0, 4)) - 64'd2;
      end
      6: f = u64_t'($urandom_range(0, 32'(clk - 64'd1)));
      7: f = u64_t'(~32'($urandom_range(0, 255)));
      8: begin
        f = u64_t'(32'd1 << $urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) f = u64_t'(~f[31:0]);
      end
      default: f = u64_t'($urandom_range(0, 1023));
    endcase
    return f[31:0];
  endfunction

  // driver: one item in flight on the input; gaps drawn after accepted items
  logic        nxt_start;
  logic [31:0] nxt_freq;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_start = start;
      nxt_freq  = lo_frequency_i;
      if (start && !busy) begin
        cmd_q.push_back(calc_tune_cmd(lo_frequency_i));
        nxt_start = 1'b0;
        if (gaps_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 18);
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (freq_q.size() > 0) begin
          nxt_start = 1'b1;
          nxt_freq  = freq_q.pop_front();
        end
      end
      start          <= nxt_start;
      lo_frequency_i <= nxt_freq;
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // monitor: results cannot be held off, so every strobe is checked at once
  tune_cmd_t want_cmd;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (cmd_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual word %h", $time,
                 tuning_word_o);
      end else begin
        want_cmd = cmd_q.pop_front();
        check_field("tuning_word", want_cmd.word, tuning_word_o);
        check_field("value_half", 32'(want_cmd.value), 32'(value_half_o));
        check_field("index_half", 32'(want_cmd.index), 32'(index_half_o));
        check_field("data_byte", 32'(want_cmd.data), 32'(data_byte_o));
        check_field("request_code", 32'(want_cmd.req), 32'(request_code_o));
      end
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MODEL) cur_model = data[1:0];
    else cur_corr = data[20:0];
  endtask

  task automatic wait_drained();
    while (freq_q.size() != 0 || start || cmd_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) freq_q.push_back(pick_freq());
  endtask

  // unused upper bits of the write data carry junk now and then
  task automatic run_phase(input logic [1:0] model, input logic [20:0] corr, input bit gaps);
    logic [31:0] junk;
    wait_drained();
    junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
    cfg_write(REG_MODEL, (junk & ~32'h3) | 32'(model));
    cfg_write(REG_CORR, (junk & ~32'h1F_FFFF) | 32'(corr));
    repeat (2) @(posedge clk_i);
    gaps_on = gaps;
    queue_random(PHASE_ITEMS);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'b1;

    // reset settings: field extremes and points around clock multiples
    freq_q.push_back(32'd0);
    freq_q.push_back(32'd1);
    freq_q.push_back(32'hFFFF_FFFF);
    freq_q.push_back(32'h8000_0000);
    freq_q.push_back(32'h7FFF_FFFF);
    freq_q.push_back(32'h5555_5555);
    freq_q.push_back(32'hAAAA_AAAA);
    freq_q.push_back(32'hFFFF_0000);
    freq_q.push_back(32'd1000);
    freq_q.push_back(32'd61440000);
    freq_q.push_back(32'd122879999);
    freq_q.push_back(32'd122880000);
    freq_q.push_back(32'd122880001);
    freq_q.push_back(32'd245760000);
    freq_q.push_back(32'd4177919999);
    freq_q.push_back(32'd4177920000);
    freq_q.push_back(32'd4177920001);
    queue_random(PHASE_ITEMS);

    run_phase(MODEL_HALF, -21'sd1000000, 1'b1);
    run_phase(MODEL_DUAL, 21'd1000000, 1'b0);
    run_phase(MODEL_SPARE, 21'd0, 1'b1);
    run_phase(MODEL_FULL, 21'h10_0000, 1'b1);
    run_phase(MODEL_HALF, 21'h0F_FFFF, 1'b0);
    run_phase(MODEL_HALF, 21'h10_0000, 1'b1);
    run_phase(MODEL_FULL, 21'h0F_FFFF, 1'b1);
    run_phase(MODEL_DUAL, 21'h10_0000, 1'b1);
    repeat (2) begin
      run_phase(2'($urandom_range(0, 3)),
                ($urandom_range(0, 1) == 1) ? 21'($urandom) :
                21'($urandom_range(0, 2000000)) - 21'd1000000, 1'b1);
    end
    run_phase(MODEL_DUAL, 21'($urandom_range(0, 2000000)) - 21'd1000000, 1'b0);
    wait_drained();

    if (cmd_q.size() != 0) begin
      errors++;
      $display("%0t: results missing: expected %0d more, actual 0", $time, cmd_q.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

FILE: nco_tuning_word_calc.f
sv/nco_tw_pkg.sv
sv/nco_tuning_word_calc.sv
sv/nco_tw_chk.sv
dv/tb_top.sv
